### hdl/stcm_pkg.sv
// ----------------------------------------------------------------------------
// stcm_pkg
// shared widths, codes and types of the strip time coincidence matcher
// ----------------------------------------------------------------------------
package stcm_pkg;

    localparam int TIME_W   = 48;
    localparam int STRIP_W  = 8;
    localparam int ENERGY_W = 16;
    localparam int WINDOW_W = 32;
    localparam int DIFF_W   = 32;

    localparam int DEF_FRONT_DEPTH = 32;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd100;

    // action codes of an input word
    localparam logic ACT_FRONT = 1'b0;
    localparam logic ACT_BACK  = 1'b1;

    // one stored front hit
    typedef struct packed {
        logic                used;
        logic [TIME_W-1:0]   hit_time;
        logic [STRIP_W-1:0]  strip;
        logic [ENERGY_W-1:0] energy;
    } t_entry;

    // running best candidate of a scan
    typedef struct packed {
        logic                have;
        logic [TIME_W-1:0]   gap;
        logic [TIME_W-1:0]   hit_time;
        logic [STRIP_W-1:0]  strip;
        logic [ENERGY_W-1:0] energy;
    } t_best;

endpackage

### hdl/stcm_store.sv
// ----------------------------------------------------------------------------
// stcm_store
// front hit memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module stcm_store #(
    parameter int FRONT_DEPTH = stcm_pkg::DEF_FRONT_DEPTH,
    parameter int IDX_W       = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  stcm_pkg::t_entry i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output stcm_pkg::t_entry o_rd_data,
    output logic             o_rd_valid,
    output logic [IDX_W-1:0] o_rd_idx
);

    stcm_pkg::t_entry r_mem [FRONT_DEPTH];
    stcm_pkg::t_entry r_rd_data;
    logic             r_rd_valid;
    logic [IDX_W-1:0] r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        r_rd_idx <= i_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_rd_en;
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;
    assign o_rd_idx   = r_rd_idx;

endmodule

### hdl/stcm_best.sv
// ----------------------------------------------------------------------------
// stcm_best
// gap stage and running minimum over the words read during a scan
// ----------------------------------------------------------------------------
module stcm_best #(
    parameter int FRONT_DEPTH = stcm_pkg::DEF_FRONT_DEPTH,
    parameter int IDX_W       = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_rd_valid,
    input  logic [IDX_W-1:0]            i_rd_idx,
    input  stcm_pkg::t_entry            i_rd_entry,
    input  logic [stcm_pkg::TIME_W-1:0] i_back_time,
    output logic                        o_pend,
    output stcm_pkg::t_best             o_best,
    output logic [IDX_W-1:0]            o_best_idx
);

    logic                        r_g_valid;
    logic                        r_g_cand;
    logic [stcm_pkg::TIME_W-1:0] r_g_gap;
    logic [IDX_W-1:0]            r_g_idx;
    stcm_pkg::t_entry            r_g_entry;
    stcm_pkg::t_best             r_best;
    logic [IDX_W-1:0]            r_best_idx;
    logic [stcm_pkg::TIME_W-1:0] gap;
    logic                        take;

    assign gap = (i_rd_entry.hit_time >= i_back_time) ? i_rd_entry.hit_time - i_back_time
                                                      : i_back_time - i_rd_entry.hit_time;

    // strict compare keeps the earliest entry on equal gaps
    assign take = r_g_valid && r_g_cand && (!r_best.have || (r_g_gap < r_best.gap));

    always_ff @(posedge i_clk) begin
        r_g_gap   <= gap;
        r_g_idx   <= i_rd_idx;
        r_g_entry <= i_rd_entry;
        r_g_cand  <= !i_rd_entry.used;
        if (take) begin
            r_best_idx <= r_g_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid   <= 1'b0;
            r_best.have <= 1'b0;
        end else begin
            r_g_valid <= i_rd_valid;
            if (i_clear) begin
                r_best.have <= 1'b0;
            end else if (take) begin
                r_best <= '{have: 1'b1, gap: r_g_gap, hit_time: r_g_entry.hit_time,
                            strip: r_g_entry.strip, energy: r_g_entry.energy};
            end
        end
    end

    assign o_pend     = r_g_valid;
    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule

### hdl/strip_time_coincidence_matcher.sv
// ----------------------------------------------------------------------------
// strip_time_coincidence_matcher
// pairs back strip hits with the nearest unused front hit of the event
// ----------------------------------------------------------------------------
// A front hit leaves busy low and the next word may follow at once. A back
// hit holds busy while the single read port of the front memory delivers
// one stored front per cycle into a two-stage compare and while that compare
// drains; there is no scan when the front store is empty. Its result is
// shown for exactly one cycle on o_strobe, in the cycle in which busy drops;
// the receiver cannot stall, so every strobe must be taken. The store needs
// no clearing pass after reset.
module strip_time_coincidence_matcher #(
    parameter int FRONT_DEPTH = stcm_pkg::DEF_FRONT_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_action,
    input  logic                                 i_new_event,
    input  logic [stcm_pkg::TIME_W-1:0]          i_hit_time,
    input  logic [stcm_pkg::STRIP_W-1:0]         i_strip,
    input  logic [stcm_pkg::ENERGY_W-1:0]        i_energy,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [stcm_pkg::WINDOW_W-1:0]        i_cfg_data,
    output logic                                 o_strobe,
    output logic                                 o_matched,
    output logic [stcm_pkg::STRIP_W-1:0]         o_front_strip,
    output logic [stcm_pkg::STRIP_W-1:0]         o_back_strip,
    output logic [stcm_pkg::ENERGY_W-1:0]        o_front_energy,
    output logic [stcm_pkg::ENERGY_W-1:0]        o_back_energy,
    output logic signed [stcm_pkg::DIFF_W-1:0]   o_time_difference
);

    localparam int IDX_W = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
    localparam int CNT_W = $clog2(FRONT_DEPTH + 1);
    localparam int TW    = stcm_pkg::TIME_W;
    localparam int DW    = stcm_pkg::DIFF_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN} t_state;

    t_state                                r_state, n_state;
    logic [CNT_W-1:0]                      r_count, n_count;
    logic [IDX_W-1:0]                      r_addr, n_addr;
    logic [stcm_pkg::WINDOW_W-1:0]         r_window;
    logic [TW-1:0]                         r_back_time;
    logic [stcm_pkg::STRIP_W-1:0]          r_back_strip;
    logic [stcm_pkg::ENERGY_W-1:0]         r_back_energy;
    logic                                  r_strobe, n_strobe;
    logic                                  r_matched, n_matched;
    logic [stcm_pkg::STRIP_W-1:0]          r_front_strip, n_front_strip;
    logic [stcm_pkg::STRIP_W-1:0]          r_out_back_strip;
    logic [stcm_pkg::ENERGY_W-1:0]         r_front_energy, n_front_energy;
    logic [stcm_pkg::ENERGY_W-1:0]         r_out_back_energy;
    logic signed [DW-1:0]                  r_diff, n_diff;

    logic                                  accept;
    logic [CNT_W-1:0]                      eff_count;
    logic                                  wr_en;
    logic [IDX_W-1:0]                      wr_addr;
    stcm_pkg::t_entry                      wr_data;
    logic                                  rd_en;
    stcm_pkg::t_entry                      rd_data;
    logic                                  rd_valid;
    logic [IDX_W-1:0]                      rd_idx;
    logic                                  scan_clear;
    logic                                  pend;
    stcm_pkg::t_best                       best;
    logic [IDX_W-1:0]                      best_idx;
    logic                                  hit;
    logic signed [TW:0]                    diff_full;
    logic signed [DW-1:0]                  diff_sat;

    stcm_store #(
        .FRONT_DEPTH (FRONT_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_addr),
        .o_rd_data  (rd_data),
        .o_rd_valid (rd_valid),
        .o_rd_idx   (rd_idx)
    );

    stcm_best #(
        .FRONT_DEPTH (FRONT_DEPTH),
        .IDX_W       (IDX_W)
    ) u_best (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (scan_clear),
        .i_rd_valid  (rd_valid),
        .i_rd_idx    (rd_idx),
        .i_rd_entry  (rd_data),
        .i_back_time (r_back_time),
        .o_pend      (pend),
        .o_best      (best),
        .o_best_idx  (best_idx)
    );

    assign accept    = start && !busy;
    assign eff_count = i_new_event ? '0 : r_count;

    assign hit = best.have && (best.gap < {{(TW - stcm_pkg::WINDOW_W){1'b0}}, r_window});

    // front minus back, clipped to the signed 32 bit range
    assign diff_full = $signed({1'b0, best.hit_time}) - $signed({1'b0, r_back_time});
    always_comb begin
        if (diff_full[TW:DW-1] == '0 || diff_full[TW:DW-1] == '1) begin
            diff_sat = diff_full[DW-1:0];
        end else if (diff_full[TW]) begin
            diff_sat = {1'b1, {(DW-1){1'b0}}};
        end else begin
            diff_sat = {1'b0, {(DW-1){1'b1}}};
        end
    end

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_addr         = r_addr;
        n_strobe       = 1'b0;
        n_matched      = r_matched;
        n_front_strip  = r_front_strip;
        n_front_energy = r_front_energy;
        n_diff         = r_diff;
        wr_en          = 1'b0;
        wr_addr        = eff_count[IDX_W-1:0];
        wr_data        = '{used: 1'b0, hit_time: i_hit_time, strip: i_strip,
                           energy: i_energy};
        rd_en          = 1'b0;
        scan_clear     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_count = eff_count;
                    if (i_action == stcm_pkg::ACT_FRONT) begin
                        // full store drops the word
                        if (eff_count < CNT_W'(FRONT_DEPTH)) begin
                            wr_en   = 1'b1;
                            n_count = eff_count + 1'b1;
                        end
                    end else begin
                        scan_clear = 1'b1;
                        n_addr     = '0;
                        n_state    = (eff_count == '0) ? S_DRAIN : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                rd_en  = 1'b1;
                n_addr = r_addr + 1'b1;
                if (CNT_W'(r_addr) == r_count - 1'b1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!rd_valid && !pend) begin
                    n_strobe       = 1'b1;
                    n_matched      = hit;
                    n_front_strip  = hit ? best.strip : '0;
                    n_front_energy = hit ? best.energy : '0;
                    n_diff         = hit ? diff_sat : '0;
                    if (hit) begin
                        wr_en   = 1'b1;
                        wr_addr = best_idx;
                        wr_data = '{used: 1'b1, hit_time: best.hit_time,
                                    strip: best.strip, energy: best.energy};
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_addr   <= '0;
            r_window <= stcm_pkg::WINDOW_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_addr   <= n_addr;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_cfg_data;
            end
        end
        if (accept && i_action == stcm_pkg::ACT_BACK) begin
            r_back_time   <= i_hit_time;
            r_back_strip  <= i_strip;
            r_back_energy <= i_energy;
        end
        r_matched      <= n_matched;
        r_front_strip  <= n_front_strip;
        r_front_energy <= n_front_energy;
        r_diff         <= n_diff;
        if (n_strobe) begin
            r_out_back_strip  <= r_back_strip;
            r_out_back_energy <= r_back_energy;
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_strobe          = r_strobe;
    assign o_matched         = r_matched;
    assign o_front_strip     = r_front_strip;
    assign o_back_strip      = r_out_back_strip;
    assign o_front_energy    = r_front_energy;
    assign o_back_energy     = r_out_back_energy;
    assign o_time_difference = r_diff;

    // a result only ever closes a back hit scan
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result word without a preceding scan");

    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_matched) |->
        (o_front_strip == '0 && o_front_energy == '0 && o_time_difference == '0))
        else $error("unmatched word carries front data");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FRONT_DEPTH))
        else $error("front count beyond store depth");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !wr_en)
        else $error("store written during a scan");

    a_busy_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> $stable(r_count))
        else $error("front count moved while busy");

endmodule
